/* design/ipu_pkg.sv */
// Shared constants and helpers for the indexed pixel unpacker.
package ipu_pkg;

    localparam int PALETTE_DEPTH = 256;
    localparam int PAL_AW        = $clog2(PALETTE_DEPTH);

    localparam logic [8:0] MAX_WIDTH  = 9'd256;
    localparam logic [8:0] MAX_HEIGHT = 9'd256;

    // Rows are padded to 32-bit words
    localparam logic [11:0] WORD_ROUND = 12'd31;

    // Register indexes on the configuration port
    localparam logic [1:0] CFG_BPP    = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;

    // Input item kinds
    localparam logic MODE_PALETTE = 1'b0;
    localparam logic MODE_DATA    = 1'b1;

    // Leftmost index of a byte, MSB first
    function automatic logic [7:0] top_index(input logic [7:0] b, input logic [3:0] bits);
        logic [7:0] r;
        case (bits)
            4'd1:    r = {7'b0, b[7]};
            4'd2:    r = {6'b0, b[7:6]};
            4'd4:    r = {4'b0, b[7:4]};
            default: r = b;
        endcase
        return r;
    endfunction

    // Drop the leftmost index
    function automatic logic [7:0] next_bits(input logic [7:0] b, input logic [3:0] bits);
        logic [7:0] r;
        case (bits)
            4'd1:    r = {b[6:0], 1'b0};
            4'd2:    r = {b[5:0], 2'b0};
            4'd4:    r = {b[3:0], 4'b0};
            default: r = 8'd0;
        endcase
        return r;
    endfunction

endpackage

/* design/indexed_pixel_unpacker.sv */
// Indexed pixel unpacker: packed bitmap bytes to palette-mapped pixels.
// A data byte is loaded into the unpack stage, which reads the palette into the output register.
// Throughput: one pixel per cycle while the output is not stalled; a byte yielding n pixels holds the
// unpack stage until all n (1 to 8) are issued. Palette writes and empty bytes take one transfer.
// Reset: counters cleared, registers to 8 bpp, 256 x 256, all palette entries read as zero.
module indexed_pixel_unpacker
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [8:0] cfg_data,

    input  logic       in_valid,
    output logic       in_ready,
    input  logic       mode,
    input  logic [7:0] palette_index,
    input  logic [7:0] palette_value,
    input  logic [7:0] data_byte,

    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] pixel_code,
    output logic [7:0] column,
    output logic [7:0] row,
    output logic       last_of_run,
    output logic       end_of_image
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [3:0] bpp_reg;
    logic [8:0] width_reg;
    logic [8:0] height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_reg    <= 4'd8;
            width_reg  <= 9'd256;
            height_reg <= 9'd256;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                ipu_pkg::CFG_BPP:    bpp_reg    <= cfg_data[3:0];
                ipu_pkg::CFG_WIDTH:  width_reg  <= cfg_data;
                ipu_pkg::CFG_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Effective geometry
    // ------------------------------------------------------------------
    logic [3:0]  eff_bits;
    logic [3:0]  pix_per_byte;
    logic [8:0]  eff_width;
    logic [8:0]  eff_height;
    logic [11:0] row_bits;
    logic [11:0] row_words;
    logic [8:0]  row_bytes;

    always_comb
    begin
        if (width_reg == 9'd0)
            eff_width = 9'd1;
        else if (width_reg > ipu_pkg::MAX_WIDTH)
            eff_width = ipu_pkg::MAX_WIDTH;
        else
            eff_width = width_reg;

        if (height_reg == 9'd0)
            eff_height = 9'd1;
        else if (height_reg > ipu_pkg::MAX_HEIGHT)
            eff_height = ipu_pkg::MAX_HEIGHT;
        else
            eff_height = height_reg;

        // unsupported depths fall back to 8 bpp
        case (bpp_reg)
            4'd1:
            begin
                eff_bits     = 4'd1;
                pix_per_byte = 4'd8;
                row_bits     = {3'b0, eff_width};
            end
            4'd2:
            begin
                eff_bits     = 4'd2;
                pix_per_byte = 4'd4;
                row_bits     = {2'b0, eff_width, 1'b0};
            end
            4'd4:
            begin
                eff_bits     = 4'd4;
                pix_per_byte = 4'd2;
                row_bits     = {1'b0, eff_width, 2'b0};
            end
            default:
            begin
                eff_bits     = 4'd8;
                pix_per_byte = 4'd1;
                row_bits     = {eff_width, 3'b0};
            end
        endcase

        // bytes per row, rounded up to whole 32-bit words
        row_words = (row_bits + ipu_pkg::WORD_ROUND) >> 5;
        row_bytes = {row_words[6:0], 2'b00};
    end

    // ------------------------------------------------------------------
    // Position tracking, updated once per accepted data byte
    // ------------------------------------------------------------------
    logic [7:0] byte_in_row_reg, byte_in_row_next;
    logic [8:0] column_count_reg, column_count_next;
    logic [7:0] source_row_reg, source_row_next;

    logic       row_end;
    logic       last_row;
    logic [7:0] out_row;
    logic [8:0] cols_left;
    logic [3:0] n_pix;

    logic       in_fire;
    logic       data_fire;
    logic       pal_we;
    logic       load_a;

    assign in_fire   = in_valid && in_ready;
    assign data_fire = in_fire && (mode == ipu_pkg::MODE_DATA);
    assign pal_we    = in_fire && (mode == ipu_pkg::MODE_PALETTE);

    always_comb
    begin
        row_end   = ({1'b0, byte_in_row_reg} + 9'd1) >= row_bytes;
        last_row  = ({1'b0, source_row_reg} + 9'd1) >= eff_height;
        out_row   = 8'(eff_height - 9'd1 - {1'b0, source_row_reg});
        cols_left = eff_width - column_count_reg;

        // pixels this byte yields: limited by row width, none in padding
        if (column_count_reg >= eff_width)
            n_pix = 4'd0;
        else if (cols_left < {5'b0, pix_per_byte})
            n_pix = cols_left[3:0];
        else
            n_pix = pix_per_byte;

        byte_in_row_next  = byte_in_row_reg;
        column_count_next = column_count_reg;
        source_row_next   = source_row_reg;
        if (data_fire)
        begin
            if (row_end)
            begin
                byte_in_row_next  = 8'd0;
                column_count_next = 9'd0;
                source_row_next   = last_row ? 8'd0 : source_row_reg + 8'd1;
            end
            else
            begin
                byte_in_row_next  = byte_in_row_reg + 8'd1;
                column_count_next = column_count_reg + {5'b0, n_pix};
            end
        end
    end

    assign load_a = data_fire && (n_pix != 4'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_in_row_reg  <= 8'd0;
            column_count_reg <= 9'd0;
            source_row_reg   <= 8'd0;
        end
        else
        begin
            byte_in_row_reg  <= byte_in_row_next;
            column_count_reg <= column_count_next;
            source_row_reg   <= source_row_next;
        end
    end

    // ------------------------------------------------------------------
    // Unpack stage: holds one byte; unless the output register is full and stalled, issues one palette read per cycle
    // ------------------------------------------------------------------
    logic       a_valid_reg, a_valid_next;
    logic [3:0] a_left_reg, a_left_next;
    logic [7:0] a_byte_reg;
    logic [3:0] a_bits_reg;
    logic [7:0] a_col_reg;
    logic [7:0] a_row_reg;
    logic [7:0] a_end_col_reg;   // width - 1
    logic       a_last_row_reg;

    logic       b_valid_reg, b_valid_next;
    logic       adv;
    logic [7:0] rd_idx;

    // advance when the output register is empty or being drained
    assign adv    = a_valid_reg && (!b_valid_reg || out_ready);
    // next transfer taken when the stage is empty or the current byte issues its final pixel
    assign in_ready = !a_valid_reg || (adv && (a_left_reg == 4'd1));
    assign rd_idx = ipu_pkg::top_index(a_byte_reg, a_bits_reg);

    always_comb
    begin
        a_valid_next = a_valid_reg;
        a_left_next  = a_left_reg;
        if (load_a)
        begin
            a_valid_next = 1'b1;
            a_left_next  = n_pix;
        end
        else if (adv)
        begin
            a_valid_next = (a_left_reg != 4'd1);
            a_left_next  = a_left_reg - 4'd1;
        end

        if (adv)
            b_valid_next = 1'b1;
        else if (out_ready)
            b_valid_next = 1'b0;
        else
            b_valid_next = b_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            a_left_reg  <= 4'd0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            a_left_reg  <= a_left_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_a)
        begin
            a_byte_reg     <= data_byte;
            a_bits_reg     <= eff_bits;
            a_col_reg      <= column_count_reg[7:0];
            a_row_reg      <= out_row;
            a_end_col_reg  <= 8'(eff_width - 9'd1);
            a_last_row_reg <= last_row;
        end
        else if (adv)
        begin
            a_byte_reg <= ipu_pkg::next_bits(a_byte_reg, a_bits_reg);
            a_col_reg  <= a_col_reg + 8'd1;
        end
    end

    // ------------------------------------------------------------------
    // Palette: RAM plus per-entry valid bits so unwritten entries read zero.
    // A write in the same cycle as a read leaves the read with the old value,
    // which is right since the write belongs to a later transfer.
    // ------------------------------------------------------------------
    logic [7:0]                       pal_mem [ipu_pkg::PALETTE_DEPTH];
    logic [ipu_pkg::PALETTE_DEPTH-1:0] pal_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pal_valid_reg <= '0;
        else if (pal_we)
            pal_valid_reg[palette_index[ipu_pkg::PAL_AW-1:0]] <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [7:0] b_data_reg;
    logic       b_hit_reg;
    logic [7:0] b_col_reg;
    logic [7:0] b_row_reg;
    logic       b_last_reg;
    logic       b_eoi_reg;

    always_ff @(posedge clk)
    begin
        if (pal_we)
            pal_mem[palette_index[ipu_pkg::PAL_AW-1:0]] <= palette_value;
        if (adv)
        begin
            b_data_reg <= pal_mem[rd_idx[ipu_pkg::PAL_AW-1:0]];
            b_hit_reg  <= pal_valid_reg[rd_idx[ipu_pkg::PAL_AW-1:0]];
            b_col_reg  <= a_col_reg;
            b_row_reg  <= a_row_reg;
            b_last_reg <= (a_left_reg == 4'd1);
            b_eoi_reg  <= a_last_row_reg && (a_col_reg == a_end_col_reg);
        end
    end

    assign out_valid    = b_valid_reg;
    assign pixel_code   = b_hit_reg ? b_data_reg : 8'd0;
    assign column       = b_col_reg;
    assign row          = b_row_reg;
    assign last_of_run  = b_last_reg;
    assign end_of_image = b_eoi_reg;

endmodule
